>>> src/abc_pkg.sv
// ============================================================================
// abc_pkg: shared types and constants of the ambient brightness controller
// Field widths, command codes, register indexes, the level ladder and the
// reset values of the per-mode brightness levels.
// ============================================================================
package abc_pkg;

    localparam int LADDER_SIZE = 12;
    localparam int MODE_COUNT  = 3;

    localparam int OP_W      = 3;
    localparam int SAMPLE_W  = 10;
    localparam int LEVEL_W   = 8;
    localparam int MODE_W    = 2;
    localparam int STEP_W    = 4;
    localparam int SUM_W     = 16;
    localparam int COUNT_W   = 8;
    localparam int THRESH_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam int HYST_LOW  = 500;
    localparam int HYST_HIGH = 1000;

    localparam logic [THRESH_W-1:0] LUX_LOW_RESET  = 16'd5000;
    localparam logic [THRESH_W-1:0] LUX_HIGH_RESET = 16'd30000;
    localparam logic [COUNT_W-1:0]  AVG_RESET      = 8'd200;
    localparam logic [MODE_W-1:0]   MODE_RESET     = 2'd1;
    localparam logic [STEP_W-1:0]   STEP_RESET     = 4'd6;

    // Command codes of the input transaction.
    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE      = 3'd0,
        OP_SET_LEVEL   = 3'd1,
        OP_STEP_UP     = 3'd2,
        OP_STEP_DOWN   = 3'd3,
        OP_SELECT_MODE = 3'd4
    } t_op;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LUX_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LUX_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_CNT  = 2'd2;

    localparam logic [LEVEL_W-1:0] LADDER [16] = '{
        8'd20, 8'd30, 8'd40, 8'd50, 8'd62, 8'd77, 8'd95, 8'd118,
        8'd146, 8'd181, 8'd214, 8'd250, 8'd255, 8'd255, 8'd255, 8'd255
    };

    localparam logic [LEVEL_W-1:0] LEVEL_RESET [4] = '{
        8'd20, 8'd95, 8'd214, 8'd214
    };

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [SAMPLE_W-1:0] sample;
        logic [LEVEL_W-1:0]  level_value;
        logic [MODE_W-1:0]   mode_value;
    } t_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] pwm_level;
        logic [MODE_W-1:0]  bright_mode;
        logic               broadcast;
        logic               save_request;
    } t_result;

    typedef struct packed {
        logic [THRESH_W-1:0] lux_low;
        logic [THRESH_W-1:0] lux_high;
        logic [COUNT_W-1:0]  average_count;
    } t_cfg;

    function automatic logic [LEVEL_W-1:0] ladder_at(input logic [STEP_W-1:0] idx);
        return LADDER[idx];
    endfunction

    // First ladder index below the top whose entry reaches the level,
    // or the top index when none does.
    function automatic logic [STEP_W-1:0] find_step(input logic [LEVEL_W-1:0] level);
        logic [STEP_W-1:0] res;
        res = STEP_W'(LADDER_SIZE - 1);
        for (int s = LADDER_SIZE - 2; s >= 0; s--) begin
            if (LADDER[s] >= level) begin
                res = STEP_W'(s);
            end
        end
        return res;
    endfunction

endpackage

>>> src/abc_in_if.sv
// ============================================================================
// abc_in_if: input channel of the brightness controller
// Valid/ready handshake carrying one command or light sample.
// ============================================================================
interface abc_in_if;
    logic                          valid;
    logic                          ready;
    logic [abc_pkg::OP_W-1:0]      op;
    logic [abc_pkg::SAMPLE_W-1:0]  sample;
    logic [abc_pkg::LEVEL_W-1:0]   level_value;
    logic [abc_pkg::MODE_W-1:0]    mode_value;

    modport source (output valid, output op, output sample, output level_value,
                    output mode_value, input ready);
    modport sink   (input valid, input op, input sample, input level_value,
                    input mode_value, output ready);
endinterface

>>> src/abc_out_if.sv
// ============================================================================
// abc_out_if: result channel of the brightness controller
// Valid/ready handshake carrying the brightness state after one transaction.
// ============================================================================
interface abc_out_if;
    logic                         valid;
    logic                         ready;
    logic [abc_pkg::LEVEL_W-1:0]  pwm_level;
    logic [abc_pkg::MODE_W-1:0]   bright_mode;
    logic                         broadcast;
    logic                         save_request;

    modport source (output valid, output pwm_level, output bright_mode,
                    output broadcast, output save_request, input ready);
    modport sink   (input valid, input pwm_level, input bright_mode,
                    input broadcast, input save_request, output ready);
endinterface

>>> src/ambient_brightness_controller_core.sv
// A transaction accepted into the input register passes through the single-pass
// state update and is captured in the output register when that register is free.
// Throughput: one transaction per clock, limited only by the output handshake.
// Reset (i_rst_n low, synchronous) restores the thresholds, the mode levels,
// mode, ladder step and accumulator to their defaults and empties both stages.
// ============================================================================
// ambient_brightness_controller_core: ambient light driven PWM brightness
// Input register, single-pass state update and output register, with a
// plain write port for the three configuration registers.
// ============================================================================
module ambient_brightness_controller_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [abc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [abc_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    abc_in_if.sink                          i_in,
    abc_out_if.source                       o_out
);

    abc_pkg::t_cfg    r_cfg;
    abc_pkg::t_item   item;
    abc_pkg::t_result result;
    abc_pkg::t_result r_out;
    logic             r_out_valid;
    logic             item_valid;
    logic             out_free;
    logic             fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{lux_low:       abc_pkg::LUX_LOW_RESET,
                       lux_high:      abc_pkg::LUX_HIGH_RESET,
                       average_count: abc_pkg::AVG_RESET};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                abc_pkg::CFG_LUX_LOW:  r_cfg.lux_low  <= i_cfg_data;
                abc_pkg::CFG_LUX_HIGH: r_cfg.lux_high <= i_cfg_data;
                abc_pkg::CFG_AVG_CNT:  r_cfg.average_count <=
                                           i_cfg_data[abc_pkg::COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The output register takes a new result when it is empty or while the old one is being read.
    assign out_free = !r_out_valid || o_out.ready;
    assign fire     = item_valid && out_free;

    abc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (out_free),
        .o_valid (item_valid),
        .o_item  (item)
    );

    abc_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.pwm_level    = r_out.pwm_level;
    assign o_out.bright_mode  = r_out.bright_mode;
    assign o_out.broadcast    = r_out.broadcast;
    assign o_out.save_request = r_out.save_request;

endmodule

>>> src/abc_in_reg.sv
// ============================================================================
// abc_in_reg: input register
// Captures one input transaction and holds it until the engine consumes it.
// ============================================================================
module abc_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    abc_in_if.sink         i_in,
    input  logic           i_take,
    output logic           o_valid,
    output abc_pkg::t_item o_item
);

    logic           r_valid;
    abc_pkg::t_item r_item;

    // The register can load whenever it is empty or is being drained.
    assign i_in.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= '{op:          i_in.op,
                        sample:      i_in.sample,
                        level_value: i_in.level_value,
                        mode_value:  i_in.mode_value};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> src/abc_engine.sv
// ============================================================================
// abc_engine: brightness state and update logic
// Holds the mode levels, current mode, ladder step, light accumulator and
// manual hold, and computes the result of one transaction in one pass.
// ============================================================================
module abc_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  abc_pkg::t_item   i_item,
    input  abc_pkg::t_cfg    i_cfg,
    output abc_pkg::t_result o_result
);

    logic [abc_pkg::LEVEL_W-1:0] r_levels [abc_pkg::MODE_COUNT];
    logic [abc_pkg::LEVEL_W-1:0] n_levels [abc_pkg::MODE_COUNT];
    logic [abc_pkg::MODE_W-1:0]  r_mode,  n_mode;
    logic [abc_pkg::STEP_W-1:0]  r_step,  n_step;
    logic [abc_pkg::SUM_W-1:0]   r_sum,   n_sum;
    logic [abc_pkg::COUNT_W-1:0] r_cnt,   n_cnt;
    logic                        r_hold,  n_hold;

    logic                        bc;
    logic                        save;
    logic                        refresh;
    logic [abc_pkg::SUM_W-1:0]   sum_new;
    logic [abc_pkg::COUNT_W:0]   cnt_next;
    logic [abc_pkg::SUM_W:0]     sum_x;
    logic [abc_pkg::SUM_W:0]     lo_x;
    logic [abc_pkg::SUM_W:0]     hi_x;
    logic [abc_pkg::STEP_W-1:0]  step_mv;

    always_comb begin
        n_levels = r_levels;
        n_mode   = r_mode;
        n_step   = r_step;
        n_sum    = r_sum;
        n_cnt    = r_cnt;
        n_hold   = r_hold;
        bc       = 1'b0;
        save     = 1'b0;
        refresh  = 1'b0;
        step_mv  = r_step;

        sum_new  = r_sum + abc_pkg::SUM_W'(i_item.sample[abc_pkg::SAMPLE_W-1:2]);
        cnt_next = {1'b0, r_cnt} + 1'b1;
        // One extra bit keeps the band edges from wrapping.
        sum_x    = {1'b0, sum_new};
        lo_x     = {1'b0, i_cfg.lux_low};
        hi_x     = {1'b0, i_cfg.lux_high};

        case (i_item.op)
            abc_pkg::OP_SAMPLE: begin
                if (cnt_next > {1'b0, i_cfg.average_count}) begin
                    if (r_hold) begin
                        save   = 1'b1;
                        n_hold = 1'b0;
                    end else begin
                        if (sum_x + (abc_pkg::SUM_W+1)'(abc_pkg::HYST_LOW) < lo_x) begin
                            n_mode = abc_pkg::MODE_W'(0);
                        end else if (sum_x > lo_x + (abc_pkg::SUM_W+1)'(abc_pkg::HYST_LOW)
                                && sum_x + (abc_pkg::SUM_W+1)'(abc_pkg::HYST_HIGH) < hi_x) begin
                            n_mode = abc_pkg::MODE_W'(1);
                        end else if (sum_x > hi_x + (abc_pkg::SUM_W+1)'(abc_pkg::HYST_HIGH)) begin
                            n_mode = abc_pkg::MODE_W'(2);
                        end
                        bc = 1'b1;
                    end
                    refresh = 1'b1;
                    n_sum   = '0;
                    n_cnt   = '0;
                end else begin
                    n_sum = sum_new;
                    n_cnt = cnt_next[abc_pkg::COUNT_W-1:0];
                end
            end
            abc_pkg::OP_SET_LEVEL: begin
                n_levels[r_mode] = i_item.level_value;
                n_hold           = 1'b1;
                bc               = 1'b1;
                refresh          = 1'b1;
            end
            abc_pkg::OP_STEP_UP: begin
                if (r_step < abc_pkg::STEP_W'(abc_pkg::LADDER_SIZE - 1)) begin
                    step_mv          = r_step + 1'b1;
                    n_levels[r_mode] = abc_pkg::ladder_at(step_mv);
                    n_hold           = 1'b1;
                    bc               = 1'b1;
                    refresh          = 1'b1;
                end
            end
            abc_pkg::OP_STEP_DOWN: begin
                if (r_step != '0) begin
                    step_mv          = r_step - 1'b1;
                    n_levels[r_mode] = abc_pkg::ladder_at(step_mv);
                    n_hold           = 1'b1;
                    bc               = 1'b1;
                    refresh          = 1'b1;
                end
            end
            abc_pkg::OP_SELECT_MODE: begin
                if (32'(i_item.mode_value) < abc_pkg::MODE_COUNT) begin
                    n_mode = i_item.mode_value;
                end
                refresh = 1'b1;
            end
            default: begin
            end
        endcase

        if (refresh) begin
            n_step = abc_pkg::find_step(n_levels[n_mode]);
        end

        o_result = '{pwm_level:    n_levels[n_mode],
                     bright_mode:  n_mode,
                     broadcast:    bc,
                     save_request: save};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < abc_pkg::MODE_COUNT; m++) begin
                r_levels[m] <= abc_pkg::LEVEL_RESET[m];
            end
            r_mode <= abc_pkg::MODE_RESET;
            r_step <= abc_pkg::STEP_RESET;
            r_sum  <= '0;
            r_cnt  <= '0;
            r_hold <= 1'b0;
        end else if (i_fire) begin
            r_levels <= n_levels;
            r_mode   <= n_mode;
            r_step   <= n_step;
            r_sum    <= n_sum;
            r_cnt    <= n_cnt;
            r_hold   <= n_hold;
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking testbench of the ambient brightness controller core
// A short table of directed transactions covers the corner cases. Random
// light scenes and manual commands follow under several threshold and
// averaging settings. Every result is checked against a model of the
// controller that runs alongside, with random idling on both channels.
// ============================================================================
module tb;
    import abc_pkg::*;

    localparam int QUIET_LIMIT     = 5000;
    localparam int PRESSURE_CYCLES = 400;
    localparam int PRESSURE_AFTER  = 150;
    localparam int REPORT_LIMIT    = 10;
    localparam int SETTLE_CYCLES   = 4;
    localparam int RESET_CYCLES    = 12;
    localparam int RESET_ROWS      = 3;
    localparam int BAND_LOW        = 500;
    localparam int BAND_HIGH       = 1000;

    // Command codes that the block does not decode.
    localparam logic [OP_W-1:0] OP_RSVD_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_HI  = 3'd7;

    localparam logic [MODE_W-1:0] MODE_DIM     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NORMAL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BRIGHT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INVALID = MODE_W'(MODE_COUNT);

    localparam logic [LEVEL_W-1:0] BRIGHTNESS_RUNGS [LADDER_SIZE] = '{
        8'd20, 8'd30, 8'd40, 8'd50, 8'd62, 8'd77, 8'd95, 8'd118,
        8'd146, 8'd181, 8'd214, 8'd250
    };

    typedef struct {
        bit      valid;
        t_result value;
    } t_literal;

    typedef struct {
        t_item    item;
        t_literal literal;
    } t_directed_row;

    typedef struct {
        t_result  predicted;
        t_literal literal;
    } t_expected_brightness;

    typedef struct {
        logic [THRESH_W-1:0] lux_low;
        logic [THRESH_W-1:0] lux_high;
        logic [COUNT_W-1:0]  window_len;
        int                  n_items;
    } t_phase;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    abc_in_if  in_ch ();
    abc_out_if out_ch ();

    ambient_brightness_controller_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #1 i_clk = ~i_clk;

    // Model state, mirroring the controller after reset.
    logic [THRESH_W-1:0] low_cfg  = 16'd5000;
    logic [THRESH_W-1:0] high_cfg = 16'd30000;
    logic [COUNT_W-1:0]  avg_cfg  = 8'd200;
    logic [LEVEL_W-1:0]  mode_level [MODE_COUNT] = '{8'd20, 8'd95, 8'd214};
    logic [MODE_W-1:0]   cur_mode  = MODE_NORMAL;
    logic [STEP_W-1:0]   rung      = 4'd6;
    logic [SUM_W-1:0]    lux_acc   = '0;
    logic [COUNT_W-1:0]  win_count = '0;
    logic                hold      = 1'b0;

    t_expected_brightness expected_brightness [$];
    t_literal             table_results [$];
    int failures      = 0;
    int results_seen  = 0;
    int quiet_cycles  = 0;
    int scene_level   = 0;
    bit pressure_done = 1'b0;
    bit sender_busy   = 1'b0;

    function automatic logic [STEP_W-1:0] rung_for(input logic [LEVEL_W-1:0] level);
        for (int i = 0; i < LADDER_SIZE - 1; i++) begin
            if (BRIGHTNESS_RUNGS[i] >= level) return STEP_W'(i);
        end
        return STEP_W'(LADDER_SIZE - 1);
    endfunction

    function automatic t_result predict_brightness(input t_item it);
        t_result res;
        logic [COUNT_W:0] next_count;
        int sum_s, lo_s, hi_s;
        res.broadcast    = 1'b0;
        res.save_request = 1'b0;
        case (it.op)
            OP_SAMPLE: begin
                next_count = {1'b0, win_count} + 1'b1;
                lux_acc = lux_acc + SUM_W'(it.sample[SAMPLE_W-1:2]);
                if (next_count > {1'b0, avg_cfg}) begin
                    // A pending manual change turns the evaluation into a save.
                    if (hold) begin
                        res.save_request = 1'b1;
                        hold = 1'b0;
                    end else begin
                        sum_s = int'(lux_acc);
                        lo_s  = int'(low_cfg);
                        hi_s  = int'(high_cfg);
                        if (sum_s < lo_s - BAND_LOW) begin
                            cur_mode = MODE_DIM;
                        end else if (sum_s > lo_s + BAND_LOW && sum_s < hi_s - BAND_HIGH) begin
                            cur_mode = MODE_NORMAL;
                        end else if (sum_s > hi_s + BAND_HIGH) begin
                            cur_mode = MODE_BRIGHT;
                        end
                        res.broadcast = 1'b1;
                    end
                    rung = rung_for(mode_level[cur_mode]);
                    lux_acc   = '0;
                    win_count = '0;
                end else begin
                    win_count = next_count[COUNT_W-1:0];
                end
            end
            OP_SET_LEVEL: begin
                mode_level[cur_mode] = it.level_value;
                hold = 1'b1;
                res.broadcast = 1'b1;
                rung = rung_for(mode_level[cur_mode]);
            end
            OP_STEP_UP: begin
                if (rung < STEP_W'(LADDER_SIZE - 1)) begin
                    mode_level[cur_mode] = BRIGHTNESS_RUNGS[rung + 1'b1];
                    hold = 1'b1;
                    res.broadcast = 1'b1;
                    rung = rung_for(mode_level[cur_mode]);
                end
            end
            OP_STEP_DOWN: begin
                if (rung > 0) begin
                    mode_level[cur_mode] = BRIGHTNESS_RUNGS[rung - 1'b1];
                    hold = 1'b1;
                    res.broadcast = 1'b1;
                    rung = rung_for(mode_level[cur_mode]);
                end
            end
            OP_SELECT_MODE: begin
                if (it.mode_value < MODE_INVALID) cur_mode = it.mode_value;
                rung = rung_for(mode_level[cur_mode]);
            end
            default: begin
            end
        endcase
        res.pwm_level   = mode_level[cur_mode];
        res.bright_mode = cur_mode;
        return res;
    endfunction

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT) $display("[%0t] %s", $time, msg);
    endfunction

    function automatic void compare_result(input t_result got, input t_result want,
                                           input string src);
        if (got.pwm_level !== want.pwm_level || got.bright_mode !== want.bright_mode ||
            got.broadcast !== want.broadcast || got.save_request !== want.save_request) begin
            note_failure($sformatf({"%s mismatch: expected level %0d mode %0d bcast %0b ",
                "save %0b, got level %0d mode %0d bcast %0b save %0b"}, src,
                want.pwm_level, want.bright_mode, want.broadcast, want.save_request,
                got.pwm_level, got.bright_mode, got.broadcast, got.save_request));
        end
    endfunction

    // Results are checked before the transaction of the same edge is
    // predicted, since a result never leaves in the cycle its input enters.
    always @(posedge i_clk) begin
        t_item got_item;
        t_result got;
        t_expected_brightness entry;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LUX_LOW:  low_cfg  = i_cfg_data;
                    CFG_LUX_HIGH: high_cfg = i_cfg_data;
                    CFG_AVG_CNT:  avg_cfg  = i_cfg_data[COUNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                got.pwm_level    = out_ch.pwm_level;
                got.bright_mode  = out_ch.bright_mode;
                got.broadcast    = out_ch.broadcast;
                got.save_request = out_ch.save_request;
                if (expected_brightness.size() == 0) begin
                    note_failure("result transaction with no transaction pending");
                end else begin
                    entry = expected_brightness.pop_front();
                    compare_result(got, entry.predicted, "model");
                    if (entry.literal.valid) compare_result(got, entry.literal.value, "table");
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                got_item.op          = in_ch.op;
                got_item.sample      = in_ch.sample;
                got_item.level_value = in_ch.level_value;
                got_item.mode_value  = in_ch.mode_value;
                if (table_results.size() != 0) begin
                    entry.literal = table_results.pop_front();
                end else begin
                    entry.literal = t_literal'{1'b0, '0};
                end
                entry.predicted = predict_brightness(got_item);
                expected_brightness.push_back(entry);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (in_ch.valid && in_ch.ready) ||
            (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int accept_run();
        if ($urandom_range(99, 0) < 25) return $urandom_range(120, 20);
        return $urandom_range(8, 1);
    endfunction

    function automatic int stall_run();
        int r;
        r = $urandom_range(99, 0);
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // Result side: random back-pressure, plus one long hold-off that fills
    // the pipeline and stalls the input channel.
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!pressure_done && results_seen >= PRESSURE_AFTER) begin
                out_ch.ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge i_clk);
                pressure_done = 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
                repeat (accept_run()) @(posedge i_clk);
                out_ch.ready <= 1'b0;
                repeat (stall_run()) @(posedge i_clk);
            end
        end
    end

    function automatic int sender_gap();
        int r;
        if (!sender_busy) return 0;
        r = $urandom_range(99, 0);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Picks a light level whose window sum lands near a threshold band, in
    // between, or anywhere in the reachable range.
    function automatic int pick_scene();
        int window, lo, hi, target, scene;
        window = int'(avg_cfg) + 1;
        lo = int'(low_cfg);
        hi = int'(high_cfg);
        case ($urandom_range(4, 0))
            0: target = int'($urandom_range(window * 255, 0));
            1: target = lo - 600 + int'($urandom_range(1200, 0));
            2: target = hi - 1200 + int'($urandom_range(2400, 0));
            3: target = (hi > lo) ? lo + int'($urandom_range(hi - lo, 0)) : lo;
            default: target = ($urandom_range(1, 0) != 0) ? 0 : window * 255;
        endcase
        scene = target * 4 / window;
        if (scene < 0) scene = 0;
        if (scene > 1023) scene = 1023;
        return scene;
    endfunction

    function automatic t_item random_item();
        t_item it;
        int pick, raw;
        it.op          = OP_SAMPLE;
        it.sample      = SAMPLE_W'($urandom_range(1023, 0));
        it.level_value = LEVEL_W'($urandom_range(255, 0));
        it.mode_value  = MODE_W'($urandom_range(3, 0));
        pick = $urandom_range(99, 0);
        if (pick < 78) begin
            if ($urandom_range(int'(avg_cfg), 0) == 0) scene_level = pick_scene();
            raw = scene_level + int'($urandom_range(32, 0)) - 16;
            if (raw < 0) raw = 0;
            if (raw > 1023) raw = 1023;
            // Now and then a reading that ignores the scene.
            if ($urandom_range(19, 0) != 0) it.sample = SAMPLE_W'(raw);
        end else if (pick < 84) begin
            it.op = OP_SET_LEVEL;
            case ($urandom_range(5, 0))
                0: it.level_value = '0;
                1: it.level_value = '1;
                default: begin
                end
            endcase
        end else if (pick < 89) begin
            it.op = OP_STEP_UP;
        end else if (pick < 94) begin
            it.op = OP_STEP_DOWN;
        end else if (pick < 98) begin
            it.op = OP_SELECT_MODE;
        end else begin
            it.op = OP_W'($urandom_range(int'(OP_RSVD_HI), int'(OP_RSVD_LO)));
        end
        return it;
    endfunction

    function automatic t_directed_row mk_row(input logic [OP_W-1:0] op, input int sample,
                                             input int level, input logic [MODE_W-1:0] sel,
                                             input bit lit, input int pwm,
                                             input logic [MODE_W-1:0] bmode,
                                             input bit bc, input bit save);
        t_directed_row row;
        row.item.op          = op;
        row.item.sample      = SAMPLE_W'(sample);
        row.item.level_value = LEVEL_W'(level);
        row.item.mode_value  = sel;
        row.literal.valid    = lit;
        row.literal.value    = '{LEVEL_W'(pwm), bmode, bc, save};
        return row;
    endfunction

    task automatic send(input t_item it, input t_literal lit);
        table_results.push_back(lit);
        in_ch.valid       <= 1'b1;
        in_ch.op          <= it.op;
        in_ch.sample      <= it.sample;
        in_ch.level_value <= it.level_value;
        in_ch.mode_value  <= it.mode_value;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            in_ch.valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_brightness.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(input t_phase ph);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LUX_LOW;
        i_cfg_data  <= ph.lux_low;
        @(posedge i_clk);
        i_cfg_index <= CFG_LUX_HIGH;
        i_cfg_data  <= ph.lux_high;
        @(posedge i_clk);
        i_cfg_index <= CFG_AVG_CNT;
        i_cfg_data  <= CFG_DAT_W'(ph.window_len);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        t_directed_row rows [$];
        t_phase phases [$];
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= '0;
        i_cfg_data        <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.op          <= '0;
        in_ch.sample      <= '0;
        in_ch.level_value <= '0;
        in_ch.mode_value  <= '0;

        // The first rows run on the reset settings, the rest on a window of
        // two samples with the lower band at 500..1500.
        rows.push_back(mk_row(OP_RSVD_LO, 0, 0, MODE_DIM, 1, 95, MODE_NORMAL, 0, 0));
        rows.push_back(mk_row(OP_RSVD_HI, 0, 0, MODE_DIM, 1, 95, MODE_NORMAL, 0, 0));
        rows.push_back(mk_row(OP_SELECT_MODE, 0, 0, MODE_INVALID, 1, 95, MODE_NORMAL, 0, 0));
        rows.push_back(mk_row(OP_SAMPLE, 1023, 0, MODE_DIM, 1, 95, MODE_NORMAL, 0, 0));
        rows.push_back(mk_row(OP_SAMPLE, 1023, 0, MODE_DIM, 1, 95, MODE_NORMAL, 1, 0));
        rows.push_back(mk_row(OP_SAMPLE, 0, 0, MODE_DIM, 1, 95, MODE_NORMAL, 0, 0));
        rows.push_back(mk_row(OP_SAMPLE, 0, 0, MODE_DIM, 1, 20, MODE_DIM, 1, 0));
        rows.push_back(mk_row(OP_STEP_DOWN, 0, 0, MODE_DIM, 1, 20, MODE_DIM, 0, 0));
        rows.push_back(mk_row(OP_STEP_UP, 0, 0, MODE_DIM, 1, 30, MODE_DIM, 1, 0));
        rows.push_back(mk_row(OP_SET_LEVEL, 0, 255, MODE_DIM, 1, 255, MODE_DIM, 1, 0));
        rows.push_back(mk_row(OP_STEP_UP, 0, 0, MODE_DIM, 1, 255, MODE_DIM, 0, 0));
        rows.push_back(mk_row(OP_SET_LEVEL, 0, 0, MODE_DIM, 1, 0, MODE_DIM, 1, 0));
        rows.push_back(mk_row(OP_STEP_DOWN, 0, 0, MODE_DIM, 1, 0, MODE_DIM, 0, 0));
        rows.push_back(mk_row(OP_SAMPLE, 3, 0, MODE_DIM, 1, 0, MODE_DIM, 0, 0));
        rows.push_back(mk_row(OP_SAMPLE, 512, 0, MODE_DIM, 1, 0, MODE_DIM, 0, 1));
        rows.push_back(mk_row(OP_SELECT_MODE, 0, 0, MODE_BRIGHT, 1, 214, MODE_BRIGHT, 0, 0));
        rows.push_back(mk_row(OP_SET_LEVEL, 0, 100, MODE_DIM, 0, 0, MODE_DIM, 0, 0));
        rows.push_back(mk_row(OP_STEP_DOWN, 0, 0, MODE_DIM, 0, 0, MODE_DIM, 0, 0));
        rows.push_back(mk_row(OP_SAMPLE, 1020, 0, MODE_DIM, 0, 0, MODE_DIM, 0, 0));
        rows.push_back(mk_row(OP_SAMPLE, 1020, 0, MODE_DIM, 1, 95, MODE_BRIGHT, 0, 1));
        rows.push_back(mk_row(OP_SAMPLE, 1023, 0, MODE_DIM, 0, 0, MODE_DIM, 0, 0));
        rows.push_back(mk_row(OP_SAMPLE, 1023, 0, MODE_DIM, 1, 95, MODE_BRIGHT, 1, 0));
        rows.push_back(mk_row(OP_RSVD_MID, 0, 0, MODE_DIM, 1, 95, MODE_BRIGHT, 0, 0));
        rows.push_back(mk_row(OP_SELECT_MODE, 0, 0, MODE_NORMAL, 1, 95, MODE_NORMAL, 0, 0));
        rows.push_back(mk_row(OP_STEP_UP, 0, 0, MODE_DIM, 0, 0, MODE_DIM, 0, 0));

        phases.push_back('{16'd1000, 16'd3000, 8'd1, 0});
        phases.push_back('{16'd501, 16'd2200, 8'd15, 350});
        phases.push_back('{16'd0, 16'd0, 8'd3, 100});
        phases.push_back('{16'd65535, 16'd65535, 8'd1, 80});
        phases.push_back('{16'd2000, 16'd5000, 8'd31, 250});
        phases.push_back('{16'd20000, 16'd40000, 8'd255, 270});

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_busy = 1'b1;
        foreach (rows[i]) begin
            if (i == RESET_ROWS) begin
                drain();
                apply_settings(phases[0]);
            end
            send(rows[i].item, rows[i].literal);
            pause_sender(sender_gap());
        end

        for (int p = 1; p < phases.size(); p++) begin
            drain();
            apply_settings(phases[p]);
            scene_level = pick_scene();
            // Some phases run with the sender never pausing.
            sender_busy = ($urandom_range(3, 0) != 0);
            for (int n = 0; n < phases[p].n_items; n++) begin
                send(random_item(), t_literal'{1'b0, '0});
                pause_sender(sender_gap());
            end
        end

        drain();
        if (expected_brightness.size() != 0) begin
            note_failure($sformatf("%0d expected results never arrived",
                                   expected_brightness.size()));
        end
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
